FILE: rtl/core/spdg_pkg.sv
// spdg_pkg: shared types, widths, constants and helpers for the
// gain-scheduled PD steering controller. No dependencies.
`timescale 1ns / 1ps

package spdg_pkg;

    // field widths
    localparam int CENTRE_W  = 12;
    localparam int ROWS_W    = 7;
    localparam int DUTY_W    = 16;
    localparam int CLIP_W    = 2;
    localparam int TARGET_W  = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // internal datapath widths
    localparam int ERR_W    = 14;   // signed error and error difference
    localparam int EMAG_W   = 12;   // magnitude of the error
    localparam int DEMAG_W  = 13;   // magnitude of the error difference
    localparam int SQ_W     = 14;   // d * d
    localparam int CUBE_W   = 22;   // d * d * d, kept even for the root
    localparam int ROOT_W   = CUBE_W / 2;
    localparam int K50_W    = 22;   // 50 * 16-bit gain
    localparam int KP50_W   = 27;   // scheduled proportional gain times 50
    localparam int MUL_A_W  = 27;
    localparam int MUL_B_W  = 14;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int TERM_W   = 40;   // magnitude of one PD term or their sum
    localparam int T_W      = TERM_W + 1;
    localparam int V_W      = 25;   // centre duty plus signed drive

    // scaling constants
    localparam int CENTRE_LIMIT   = 2048;
    localparam int IMAGE_ROWS_DEF = 70;
    localparam int GAIN_DIVISOR   = 50;
    localparam int FRAC_SCALE     = 4096;
    localparam int DRIVE_DIVISOR  = GAIN_DIVISOR * FRAC_SCALE;

    // quotient width of the drive divider
    localparam int DIV_SKIP = $clog2(DRIVE_DIVISOR) - 1;
    localparam int QUO_W    = TERM_W - DIV_SKIP;

    // register reset values
    localparam logic [CFG_W-1:0]    KP_BASE_RST     = 16'd256;
    localparam logic [CFG_W-1:0]    KP_SLOPE_RST    = 16'd0;
    localparam logic [CFG_W-1:0]    KD_GAIN_RST     = 16'd0;
    localparam logic [CFG_W-1:0]    CENTRE_DUTY_RST = 16'd32768;
    localparam logic [CFG_W-1:0]    MAX_DUTY_RST    = 16'd65535;
    localparam logic [CFG_W-1:0]    MIN_DUTY_RST    = 16'd0;
    localparam logic [TARGET_W-1:0] TARGET_RST      = 8'd64;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_BASE     = 3'd0,
        CFG_KP_SLOPE    = 3'd1,
        CFG_KD_GAIN     = 3'd2,
        CFG_CENTRE_DUTY = 3'd3,
        CFG_MAX_DUTY    = 3'd4,
        CFG_MIN_DUTY    = 3'd5,
        CFG_TARGET      = 3'd6
    } t_cfg_idx;

    // clamp flag codes
    typedef enum logic [CLIP_W-1:0] {
        CLIP_NONE = 2'd0,
        CLIP_MAX  = 2'd1,
        CLIP_MIN  = 2'd2
    } t_clip;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_CUBE,
        S_ROOT,
        S_SLOPE,
        S_PTERM,
        S_DTERM,
        S_DIV,
        S_OUT
    } t_state;

    // multiply a 16-bit gain by fifty with shifts and adds
    function automatic logic [K50_W-1:0] times50(input logic [CFG_W-1:0] x);
        times50 = {1'b0, x, 5'b0} + {2'b0, x, 4'b0} + {5'b0, x, 1'b0};
    endfunction

endpackage

FILE: rtl/core/spdg_item_if.sv
// spdg_item_if: input channel of the steering controller, valid/ready
// with lane centre and row count. Depends on spdg_pkg.
`timescale 1ns / 1ps

interface spdg_item_if;
    import spdg_pkg::*;

    logic                valid;
    logic                ready;
    logic [CENTRE_W-1:0] centre_pos;
    logic [ROWS_W-1:0]   rows_used;

    modport source (output valid, output centre_pos, output rows_used, input ready);
    modport sink   (input valid, input centre_pos, input rows_used, output ready);
endinterface

FILE: rtl/core/spdg_result_if.sv
// spdg_result_if: result channel of the steering controller, valid/ready
// with servo duty and clamp flag. Depends on spdg_pkg.
`timescale 1ns / 1ps

interface spdg_result_if;
    import spdg_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic [CLIP_W-1:0] clipped;

    modport source (output valid, output duty, output clipped, input ready);
    modport sink   (input valid, input duty, input clipped, output ready);
endinterface

FILE: rtl/core/spdg_mul.sv
// spdg_mul: bit-serial unsigned shift-add multiplier, one multiplier bit
// per cycle. Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module spdg_mul #(
    parameter int WA = 27,
    parameter int WB = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WA-1:0] i_a,
    input  logic [WB-1:0] i_b,
    output logic          o_done,
    output logic [WA+WB-1:0] o_prod
);
    localparam int CW = $clog2(WB + 1);

    logic [WA-1:0] r_a;
    logic [WA:0]   r_hi;
    logic [WB-1:0] r_lo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [WA:0]   n_sum;

    // partial sum for the current multiplier bit
    always_comb begin
        n_sum = r_hi + (r_lo[0] ? {1'b0, r_a} : '0);
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // accumulate and shift right
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= {1'b0, n_sum[WA:1]};
            r_lo <= {n_sum[0], r_lo[WB-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[WA-1:0], r_lo};

endmodule

FILE: rtl/core/spdg_isqrt.sv
// spdg_isqrt: digit-by-digit floor square root, one two-bit digit of the
// operand per cycle. Depends on nothing beyond its parameter.
`timescale 1ns / 1ps

module spdg_isqrt #(
    parameter int W = 22
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_val,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);
    localparam int HW = W / 2;
    localparam int RW = HW + 2;
    localparam int CW = $clog2(HW + 1);

    logic [W-1:0]  r_m;
    logic [RW-1:0] r_rem;
    logic [HW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [RW-1:0] n_rem_sh;
    logic [RW-1:0] n_trial;

    // bring down the next digit pair and form the trial value
    always_comb begin
        n_rem_sh = {r_rem[RW-3:0], r_m[W-1:W-2]};
        n_trial  = {r_root, 2'b01};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(HW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one root bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_m <= {r_m[W-3:0], 2'b00};
            if (n_rem_sh >= n_trial) begin
                r_rem  <= n_rem_sh - n_trial;
                r_root <= {r_root[HW-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem_sh;
                r_root <= {r_root[HW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: rtl/core/spdg_div.sv
// spdg_div: bit-serial restoring divider of an unsigned value by a fixed
// divisor, one quotient bit per cycle. Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module spdg_div #(
    parameter int WN      = 40,
    parameter int DIVISOR = 204800
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [WN-1:0]  i_num,
    output logic           o_done,
    output logic [WN-$clog2(DIVISOR):0] o_quo
);
    localparam int DW   = $clog2(DIVISOR);
    localparam int SKIP = DW - 1;        // leading bits that stay below the divisor
    localparam int QW   = WN - SKIP;
    localparam int RW   = DW + 1;
    localparam int CW   = $clog2(QW + 1);
    localparam logic [RW-1:0] DIV_C = RW'(DIVISOR);

    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_num;
    logic [QW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [RW-1:0] n_trial;

    // partial remainder with the next dividend bit
    always_comb begin
        n_trial = {r_rem[RW-2:0], r_num[QW-1]};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // subtract where it fits, shift in the quotient bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_num[WN-1 -: SKIP]};
            r_num <= i_num[QW-1:0];
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[QW-2:0], 1'b0};
            if (n_trial >= DIV_C) begin
                r_rem <= n_trial - DIV_C;
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= n_trial;
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/core/steering_pd_gain_scheduled.sv
// steering_pd_gain_scheduled: gain-scheduled PD steering controller.
// Channels: i_item carries centre_pos (1/16 px) and rows_used; o_result
// carries the servo duty and a clamp flag (0 in range, 1 at max_duty,
// 2 at min_duty). Both are valid/ready; an item moves when both are high.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (kp_base, kp_slope, kd_gain, centre_duty, max_duty, min_duty,
// target_centre); unknown indexes are dropped. Write only while idle.
// Sequencing: a sequencer takes one item at a time and runs it through
// a bit-serial multiplier (five products: d*d, d^2*d, root*kp_slope,
// Kp*|e|, Kd*|de|), an 11-step digit square root and a 23-step
// restoring divider by 204800. A new item is taken only in the idle
// state that follows the loading of the output register, so an item
// is never accepted before the previous result is registered.
// Stall: a result waits in the output register while the next item is
// accepted and computed; that item then waits until the register drains.
// Reset: synchronous, active low; registers return to defaults, the
// stored previous error clears and any item in flight is dropped.
// Depends on spdg_pkg, spdg_item_if, spdg_result_if, spdg_mul,
// spdg_isqrt and spdg_div.
`timescale 1ns / 1ps

module steering_pd_gain_scheduled #(
    parameter int IMAGE_ROWS = spdg_pkg::IMAGE_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spdg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spdg_pkg::CFG_W-1:0]        i_cfg_data,
    spdg_item_if.sink                         i_item,
    spdg_result_if.source                     o_result
);
    import spdg_pkg::*;

    localparam logic [ROWS_W-1:0]   ROWS_MAX = ROWS_W'(IMAGE_ROWS);
    localparam logic [CENTRE_W-1:0] C_LIMIT  = CENTRE_W'(CENTRE_LIMIT);

    // configuration registers
    logic [CFG_W-1:0]    r_kp_base;
    logic [CFG_W-1:0]    r_kp_slope;
    logic [CFG_W-1:0]    r_kd_gain;
    logic [CFG_W-1:0]    r_centre_duty;
    logic [CFG_W-1:0]    r_max_duty;
    logic [CFG_W-1:0]    r_min_duty;
    logic [TARGET_W-1:0] r_target;

    // sequencer
    t_state r_state, n_state;
    logic   r_go, n_go;
    logic   accept;
    logic   out_load;

    // item datapath
    logic signed [ERR_W-1:0] r_prev;
    logic [EMAG_W-1:0]       r_e_mag;
    logic                    r_e_neg;
    logic [DEMAG_W-1:0]      r_de_mag;
    logic                    r_de_neg;
    logic [ROWS_W-1:0]       r_d;
    logic [SQ_W-1:0]         r_sq;
    logic [CUBE_W-1:0]       r_cube;
    logic [ROOT_W-1:0]       r_root;
    logic [KP50_W-1:0]       r_kp50;
    logic signed [T_W-1:0]   r_t;

    logic r_out_valid;
    logic [DUTY_W-1:0] r_duty;
    t_clip             r_clip;

    logic [CENTRE_W-1:0]     c_clamp;
    logic [ROWS_W-1:0]       rows_clamp;
    logic signed [ERR_W-1:0] e_val;
    logic signed [ERR_W-1:0] de_val;
    logic [ERR_W-1:0]        e_abs;
    logic [ERR_W-1:0]        de_abs;

    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic               root_start, root_done;
    logic [ROOT_W-1:0]  root_val;
    logic               div_start, div_done;
    logic [TERM_W-1:0]  div_num;
    logic [QUO_W-1:0]   div_quo;

    logic signed [T_W-1:0] term_ext;
    logic signed [T_W-1:0] t_abs;
    logic signed [V_W-1:0] drive;
    logic signed [V_W-1:0] v_sum;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_base     <= KP_BASE_RST;
            r_kp_slope    <= KP_SLOPE_RST;
            r_kd_gain     <= KD_GAIN_RST;
            r_centre_duty <= CENTRE_DUTY_RST;
            r_max_duty    <= MAX_DUTY_RST;
            r_min_duty    <= MIN_DUTY_RST;
            r_target      <= TARGET_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KP_BASE:     r_kp_base     <= i_cfg_data;
                CFG_KP_SLOPE:    r_kp_slope    <= i_cfg_data;
                CFG_KD_GAIN:     r_kd_gain     <= i_cfg_data;
                CFG_CENTRE_DUTY: r_centre_duty <= i_cfg_data;
                CFG_MAX_DUTY:    r_max_duty    <= i_cfg_data;
                CFG_MIN_DUTY:    r_min_duty    <= i_cfg_data;
                CFG_TARGET:      r_target      <= i_cfg_data[TARGET_W-1:0];
                default:         ;
            endcase
        end
    end

    // error, error difference and missing rows at accept
    always_comb begin
        c_clamp    = (i_item.centre_pos > C_LIMIT) ? C_LIMIT : i_item.centre_pos;
        rows_clamp = (i_item.rows_used > ROWS_MAX) ? ROWS_MAX : i_item.rows_used;
        e_val      = $signed({2'b00, r_target, 4'b0000}) - $signed({2'b00, c_clamp});
        de_val     = e_val - r_prev;
        e_abs      = e_val[ERR_W-1] ? ERR_W'(-e_val) : ERR_W'(e_val);
        de_abs     = de_val[ERR_W-1] ? ERR_W'(-de_val) : ERR_W'(de_val);
    end

    assign accept = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_go     = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SQ;
                    n_go    = 1'b1;
                end
            end
            S_SQ: begin
                if (mul_done) begin
                    n_state = S_CUBE;
                    n_go    = 1'b1;
                end
            end
            S_CUBE: begin
                if (mul_done) begin
                    n_state = S_ROOT;
                    n_go    = 1'b1;
                end
            end
            S_ROOT: begin
                if (root_done) begin
                    n_state = S_SLOPE;
                    n_go    = 1'b1;
                end
            end
            S_SLOPE: begin
                if (mul_done) begin
                    n_state = S_PTERM;
                    n_go    = 1'b1;
                end
            end
            S_PTERM: begin
                if (mul_done) begin
                    n_state = S_DTERM;
                    n_go    = 1'b1;
                end
            end
            S_DTERM: begin
                if (mul_done) begin
                    n_state = S_DIV;
                    n_go    = 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // unit launches
    assign mul_start  = r_go && (r_state == S_SQ || r_state == S_CUBE ||
                                 r_state == S_SLOPE || r_state == S_PTERM ||
                                 r_state == S_DTERM);
    assign root_start = r_go && (r_state == S_ROOT);
    assign div_start  = r_go && (r_state == S_DIV);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = MUL_A_W'(r_d);
                mul_b = MUL_B_W'(r_d);
            end
            S_CUBE: begin
                mul_a = MUL_A_W'(r_sq);
                mul_b = MUL_B_W'(r_d);
            end
            S_SLOPE: begin
                mul_a = MUL_A_W'(r_kp_slope);
                mul_b = MUL_B_W'(r_root);
            end
            S_PTERM: begin
                mul_a = r_kp50;
                mul_b = MUL_B_W'(r_e_mag);
            end
            S_DTERM: begin
                mul_a = MUL_A_W'(times50(r_kd_gain));
                mul_b = MUL_B_W'(r_de_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // signed products and the drive
    always_comb begin
        term_ext = $signed({1'b0, mul_prod[TERM_W-1:0]});
        t_abs    = r_t[T_W-1] ? -r_t : r_t;
        drive    = r_t[T_W-1] ? -$signed(V_W'(div_quo)) : $signed(V_W'(div_quo));
        v_sum    = $signed({{(V_W - DUTY_W){1'b0}}, r_centre_duty}) + drive;
    end
    assign div_num = t_abs[TERM_W-1:0];

    // previous error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (accept) begin
            r_prev <= e_val;
        end
    end

    // item datapath captures
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e_mag  <= e_abs[EMAG_W-1:0];
            r_e_neg  <= e_val[ERR_W-1];
            r_de_mag <= de_abs[DEMAG_W-1:0];
            r_de_neg <= de_val[ERR_W-1];
            r_d      <= ROWS_MAX - rows_clamp;
        end
        if (mul_done && r_state == S_SQ) begin
            r_sq <= mul_prod[SQ_W-1:0];
        end
        if (mul_done && r_state == S_CUBE) begin
            r_cube <= mul_prod[CUBE_W-1:0];
        end
        if (root_done && r_state == S_ROOT) begin
            r_root <= root_val;
        end
        if (mul_done && r_state == S_SLOPE) begin
            r_kp50 <= mul_prod[KP50_W-1:0] + KP50_W'(times50(r_kp_base));
        end
        if (mul_done && r_state == S_PTERM) begin
            r_t <= r_e_neg ? -term_ext : term_ext;
        end
        if (mul_done && r_state == S_DTERM) begin
            r_t <= r_de_neg ? (r_t - term_ext) : (r_t + term_ext);
        end
    end

    // output register with clamping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (v_sum > $signed({{(V_W - DUTY_W){1'b0}}, r_max_duty})) begin
                r_duty <= r_max_duty;
                r_clip <= CLIP_MAX;
            end else if (v_sum < $signed({{(V_W - DUTY_W){1'b0}}, r_min_duty})) begin
                r_duty <= r_min_duty;
                r_clip <= CLIP_MIN;
            end else begin
                r_duty <= v_sum[DUTY_W-1:0];
                r_clip <= CLIP_NONE;
            end
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.duty    = r_duty;
    assign o_result.clipped = r_clip;

    // shared serial multiplier
    spdg_mul #(
        .WA (MUL_A_W),
        .WB (MUL_B_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // square root of the cube of missing rows
    spdg_isqrt #(
        .W (CUBE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_val   (r_cube),
        .o_done  (root_done),
        .o_root  (root_val)
    );

    // drive scaling divider
    spdg_div #(
        .WN      (TERM_W),
        .DIVISOR (DRIVE_DIVISOR)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // reset returns the sequencer to idle
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_IDLE))
        else $error("sequencer not idle after reset");

    // an accepted item launches the first product
    a_accept_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SQ && r_go))
        else $error("accepted item did not start the multiplier");

    // multiplier completions only in multiply states
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_SQ || r_state == S_CUBE || r_state == S_SLOPE ||
                      r_state == S_PTERM || r_state == S_DTERM))
        else $error("multiplier finished outside a multiply state");

    // root and divider finish only in their own states
    a_unit_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!root_done || r_state == S_ROOT) && (!div_done || r_state == S_DIV))
        else $error("serial unit finished out of sequence");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !out_load)
        else $error("result overwritten while stalled");

endmodule

FILE: dv/steering_pd_gain_scheduled_tb.sv
// steering_pd_gain_scheduled_tb: self-checking bench for steering_pd_gain_scheduled.
// Directed rows are checked against typed duties or a local duty predictor, random
// phases against the predictor. Depends on spdg_pkg, spdg_item_if and spdg_result_if.
`timescale 1ns / 1ps

module steering_pd_gain_scheduled_tb;
    import spdg_pkg::*;

    localparam int STEER_ROWS    = IMAGE_ROWS_DEF;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 140;     // settle time after the last result
    localparam int HOLD_CYCLES   = 1000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int CYCLE_LIMIT   = 2000000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    // one row of the directed table: an item or a register write
    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [CENTRE_W-1:0]  centre;
        logic [ROWS_W-1:0]    rows;
        logic                 typed;
        logic [DUTY_W-1:0]    duty;
        t_clip                clip;
    } t_step_row;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        t_clip             clip;
    } t_duty_exp;

    localparam int DIRECTED_ROWS = 34;
    localparam t_step_row DIRECTED_STEPS [DIRECTED_ROWS] = '{
        // reset settings: drive is e/16
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd1024, 7'd70, 1'b1, 16'd32768, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd0, 7'd0, 1'b1, 16'd32832, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd4095, 7'd127, 1'b1, 16'd32704, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd2048, 7'd71, 1'b1, 16'd32704, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd2049, 7'd70, 1'b1, 16'd32704, CLIP_NONE},
        // full scheduled and derivative gain
        '{ROW_CFG, CFG_KP_SLOPE, 16'hFFFF, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_CFG, CFG_KD_GAIN, 16'hFFFF, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd4095, 7'd127, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd1024, 7'd70, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd1000, 7'd1, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_CFG, CFG_KP_BASE, 16'hFFFF, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd4095, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        // back to plain gain, narrow duty window
        '{ROW_CFG, CFG_KP_BASE, 16'd256, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_CFG, CFG_KP_SLOPE, 16'd0, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_CFG, CFG_KD_GAIN, 16'd0, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_CFG, CFG_MAX_DUTY, 16'd100, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_CFG, CFG_MIN_DUTY, 16'd50, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd1024, 7'd35, 1'b1, 16'd100, CLIP_MAX},
        '{ROW_CFG, CFG_CENTRE_DUTY, 16'd0, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd1024, 7'd35, 1'b1, 16'd50, CLIP_MIN},
        // crossed limits: min above max
        '{ROW_CFG, CFG_MIN_DUTY, 16'd200, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd1024, 7'd35, 1'b1, 16'd200, CLIP_MIN},
        '{ROW_CFG, CFG_CENTRE_DUTY, 16'd32768, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd1024, 7'd35, 1'b1, 16'd100, CLIP_MAX},
        // target extremes
        '{ROW_CFG, CFG_MAX_DUTY, 16'hFFFF, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_CFG, CFG_MIN_DUTY, 16'd0, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_CFG, CFG_TARGET, 16'd255, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd0, 7'd70, 1'b1, 16'd33023, CLIP_NONE},
        '{ROW_CFG, CFG_TARGET, 16'd0, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd2048, 7'd64, 1'b1, 16'd32640, CLIP_NONE},
        // write to an unknown index must change nothing
        '{ROW_CFG, CFG_IDX_UNUSED, 16'hFFFF, 12'd0, 7'd0, 1'b0, 16'd0, CLIP_NONE},
        '{ROW_ITEM, CFG_KP_BASE, 16'd0, 12'd0, 7'd0, 1'b1, 16'd32768, CLIP_NONE}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    spdg_item_if   item_if ();
    spdg_result_if result_if ();

    steering_pd_gain_scheduled #(
        .IMAGE_ROWS (STEER_ROWS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // predictor copy of registers and stored error
    int m_kp_base     = int'(KP_BASE_RST);
    int m_kp_slope    = int'(KP_SLOPE_RST);
    int m_kd_gain     = int'(KD_GAIN_RST);
    int m_centre_duty = int'(CENTRE_DUTY_RST);
    int m_max_duty    = int'(MAX_DUTY_RST);
    int m_min_duty    = int'(MIN_DUTY_RST);
    int m_target      = int'(TARGET_RST);
    int last_error    = 0;

    t_duty_exp duty_expected_q [$];

    int   send_idle_pct   = 0;
    int   recv_stall_pct  = 0;
    logic pressure_req    = 1'b0;
    int   items_sent      = 0;
    int   results_checked = 0;
    int   mismatch_count  = 0;
    int   cycle_count     = 0;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // timeout
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d results still expected", $time, duty_expected_q.size());
        $display("steering_pd_gain_scheduled_tb NOT OK");
        $finish;
    end

    // expected duty and clamp flag for one item; advances the stored error
    task automatic predict_duty(input logic [CENTRE_W-1:0] centre, input logic [ROWS_W-1:0] rows,
                                output logic [DUTY_W-1:0] duty, output t_clip clip);
        int     c;
        int     r;
        int     e;
        int     de;
        int     d;
        int     cube;
        int     root;
        longint gain50;
        longint total;
        longint drive;
        longint level;
        c = (int'(centre) > CENTRE_LIMIT) ? CENTRE_LIMIT : int'(centre);
        e = m_target * 16 - c;
        de = e - last_error;
        last_error = e;
        r = (int'(rows) > STEER_ROWS) ? STEER_ROWS : int'(rows);
        d = STEER_ROWS - r;
        cube = d * d * d;
        // floor square root by search, cube stays below 2^19
        root = 0;
        while ((root + 1) * (root + 1) <= cube)
            root++;
        gain50 = longint'(m_kp_base) * GAIN_DIVISOR + longint'(root) * longint'(m_kp_slope);
        total = gain50 * e + longint'(m_kd_gain) * GAIN_DIVISOR * de;
        drive = total / DRIVE_DIVISOR;
        level = longint'(m_centre_duty) + drive;
        if (level > m_max_duty) begin
            duty = DUTY_W'(m_max_duty);
            clip = CLIP_MAX;
        end else if (level < m_min_duty) begin
            duty = DUTY_W'(m_min_duty);
            clip = CLIP_MIN;
        end else begin
            duty = DUTY_W'(level);
            clip = CLIP_NONE;
        end
    endtask

    // register write, then update the predictor copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_KP_BASE:     m_kp_base = int'(data);
            CFG_KP_SLOPE:    m_kp_slope = int'(data);
            CFG_KD_GAIN:     m_kd_gain = int'(data);
            CFG_CENTRE_DUTY: m_centre_duty = int'(data);
            CFG_MAX_DUTY:    m_max_duty = int'(data);
            CFG_MIN_DUTY:    m_min_duty = int'(data);
            CFG_TARGET:      m_target = int'(data[TARGET_W-1:0]);
            default: ;
        endcase
    endtask

    // stop offering, wait for every expected result, then settle
    task automatic wait_idle(input int extra);
        item_if.valid <= 1'b0;
        while (duty_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // offer one item after a random gap and record its expected result
    task automatic send_item(input logic [CENTRE_W-1:0] centre, input logic [ROWS_W-1:0] rows,
                             input logic typed, input logic [DUTY_W-1:0] typed_duty,
                             input t_clip typed_clip);
        t_duty_exp         want;
        logic [DUTY_W-1:0] p_duty;
        t_clip             p_clip;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.centre_pos <= centre;
        item_if.rows_used  <= rows;
        do
            @(posedge i_clk);
        while (!item_if.ready);
        predict_duty(centre, rows, p_duty, p_clip);
        want.duty = typed ? typed_duty : p_duty;
        want.clip = typed ? typed_clip : p_clip;
        duty_expected_q.push_back(want);
        items_sent++;
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        int hold_count;
        hold_count = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_req && hold_count < HOLD_CYCLES) begin
                result_if.ready <= 1'b0;
                hold_count++;
            end else begin
                result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        t_duty_exp want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (duty_expected_q.size() == 0) begin
                $display("%0t: result with no item waiting: duty %0d clipped %0d",
                         $time, result_if.duty, result_if.clipped);
                mismatch_count++;
            end else begin
                want = duty_expected_q.pop_front();
                results_checked++;
                if (result_if.duty !== want.duty) begin
                    $display("%0t: duty mismatch: expected %0d actual %0d",
                             $time, want.duty, result_if.duty);
                    mismatch_count++;
                end
                if (result_if.clipped !== want.clip) begin
                    $display("%0t: clipped mismatch: expected %0d actual %0d",
                             $time, want.clip, result_if.clipped);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        t_step_row           row;
        logic [CFG_W-1:0]    kb;
        logic [CFG_W-1:0]    ks;
        logic [CFG_W-1:0]    kd;
        logic [CFG_W-1:0]    cd;
        logic [CFG_W-1:0]    mx;
        logic [CFG_W-1:0]    mn;
        logic [TARGET_W-1:0] tg;
        logic [CENTRE_W-1:0] centre;
        logic [ROWS_W-1:0]   rows;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_KP_BASE;
        i_cfg_data         <= '0;
        item_if.valid      <= 1'b0;
        item_if.centre_pos <= '0;
        item_if.rows_used  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling
        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            row = DIRECTED_STEPS[k];
            if (row.kind == ROW_CFG) begin
                wait_idle(SETTLE_CYCLES);
                write_reg(row.idx, row.data);
            end else begin
                send_item(row.centre, row.rows, row.typed, row.duty, row.clip);
            end
        end

        // random phases, each with its own settings and idle mode
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: begin
                    kb = 16'hFFFF; ks = 16'hFFFF; kd = 16'hFFFF;
                    cd = 16'hFFFF; mx = 16'hFFFF; mn = 16'h0000; tg = 8'hFF;
                end
                2: begin
                    kb = '0; ks = '0; kd = '0; cd = '0; mx = '0; mn = '0; tg = '0;
                end
                3: begin
                    kb = CFG_W'($urandom); ks = CFG_W'($urandom); kd = CFG_W'($urandom);
                    cd = CFG_W'($urandom); mx = CFG_W'($urandom); mn = CFG_W'($urandom);
                    tg = TARGET_W'($urandom);
                end
                default: begin
                    kb = CFG_W'($urandom_range(0, 4095));
                    ks = CFG_W'($urandom_range(0, 2047));
                    kd = CFG_W'($urandom_range(0, 8191));
                    cd = CFG_W'($urandom_range(16384, 49151));
                    mx = cd + CFG_W'($urandom_range(0, 16383));
                    mn = cd - CFG_W'($urandom_range(0, 16383));
                    tg = TARGET_W'($urandom_range(0, 255));
                end
            endcase
            wait_idle(SETTLE_CYCLES);
            write_reg(CFG_KP_BASE, kb);
            write_reg(CFG_KP_SLOPE, ks);
            write_reg(CFG_KD_GAIN, kd);
            write_reg(CFG_CENTRE_DUTY, cd);
            write_reg(CFG_MAX_DUTY, mx);
            write_reg(CFG_MIN_DUTY, mn);
            write_reg(CFG_TARGET, {{(CFG_W-TARGET_W){1'b0}}, tg});

            // idle mode: none, sender, receiver, both
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4 && n == 50)
                    pressure_req <= 1'b1;
                // mostly in-range centres and rows, sometimes the full field
                if ($urandom_range(0, 9) < 7)
                    centre = CENTRE_W'($urandom_range(0, 2100));
                else
                    centre = CENTRE_W'($urandom);
                if ($urandom_range(0, 9) < 7)
                    rows = ROWS_W'($urandom_range(0, STEER_ROWS));
                else
                    rows = ROWS_W'($urandom);
                send_item(centre, rows, 1'b0, '0, CLIP_NONE);
            end
        end

        wait_idle(DRAIN_CYCLES);
        $display("covered %0d items: directed extremes and clamps, then %0d setting phases",
                 items_sent, NUM_PHASES);
        $display("with every idle mode and one long output hold; %0d results in %0d cycles",
                 results_checked, cycle_count);
        if (mismatch_count == 0) begin
            $display("steering_pd_gain_scheduled_tb OK");
        end else begin
            $display("steering_pd_gain_scheduled_tb NOT OK");
        end
        $finish;
    end

endmodule
